>>> hw/rtl/power_cell_assign_mass_gradient_top_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef POWER_CELL_ASSIGN_MASS_GRADIENT_TOP_MACROS_SVH
`define POWER_CELL_ASSIGN_MASS_GRADIENT_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCAMG_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCAMG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pcamg_pkg.sv
package pcamg_pkg;

    // Sizing of the site store and of the coordinates.
    localparam int MAX_SITES  = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_SITES);

    // Fixed field widths.
    localparam int SITE_W  = 6;
    localparam int POS_W   = 16;
    localparam int W_W     = 32;
    localparam int H_W     = 32;
    localparam int MASS_W  = 38;
    localparam int NORM_W  = 62;
    localparam int SCORE_W = 48;
    localparam int STEP_W  = 16;
    localparam int NSITE_W = 7;

    // Stream widths.
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 192;
    localparam int CFG_ADDR_W = 2;

    // Score datapath widths.
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SC_W   = ((SQ_W + 2 > H_W) ? SQ_W + 2 : H_W) + 2;

    // Gradient datapath widths.
    localparam int G_W = MASS_W + 1;
    localparam int P_W = STEP_W + 1 + G_W;

    localparam logic [MASS_W-1:0] MASS_MAX = '1;
    localparam logic [NORM_W-1:0] NORM_MAX = '1;
    localparam longint SCORE_MAX = (64'sd1 <<< (SCORE_W - 1)) - 64'sd1;
    localparam longint SCORE_MIN = -SCORE_MAX - 64'sd1;

    // Operation codes carried on tuser.
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_POINT  = 2'd1,
        OP_FINISH = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_SITES = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_THR   = 2'd2;

    // What a sweep through the site store computes.
    typedef enum logic [1:0] {
        SW_POINT = 2'd0,
        SW_NORM  = 2'd1,
        SW_UPD   = 2'd2,
        SW_MASS  = 2'd3
    } sweep_t;

    // Read address source.
    typedef enum logic [1:0] {
        ASEL_CNT  = 2'd0,
        ASEL_WIN  = 2'd1,
        ASEL_ITEM = 2'd2
    } asel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             capture;
        logic             wr_site;
        logic             rd_en;
        asel_t            asel;
        logic [IDX_W-1:0] addr;
        logic             first;
        sweep_t           mode;
        logic             acc_wr;
        logic             clear_mass;
        logic             out_load;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] last_idx;
        logic             converged;
    } sts_t;

endpackage

>>> hw/rtl/power_cell_assign_mass_gradient_top.sv
// Power-diagram site assignment with a gradient step on the site offsets.
// Input beats arrive on the s_ stream: s_tuser holds the operation (load
// site, point, finish pass, read site) and s_tdata the site index, position,
// weight and initial offset. Each input beat gives exactly one result beat
// on the m_ stream, with the operation echoed on m_tuser.
// The block handles one beat at a time. The site store has one read port,
// so a point search reads one site per cycle for the n sites in use through
// a three-stage score pipeline, then updates the winner's mass. A finish
// pass also sweeps the offsets when it has not converged. Settings are to
// be written on the cfg_ port only while the block is idle; the block
// itself does not enforce this.
// Reset restores the settings, empties the result register and marks every
// mass accumulator as zero at once; site data is undefined until loaded.
// A stalled receiver holds the result in the output register; the block
// still accepts and works on the next beat, and waits only to hand it over.
module power_cell_assign_mass_gradient_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // site_index[5:0], pos_x[21:6], pos_y[37:22], pos_z[53:38],
    // weight[85:54], initial_offset[117:86], zero fill above
    input  logic [pcamg_pkg::IN_DATA_W-1:0]      s_tdata,
    // operation[1:0]
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // assigned_site[5:0], best_score[53:6], cell_mass[91:54],
    // site_offset[123:92], grad_norm_sq[185:124], converged[186],
    // offset_nonpositive[187], zero fill above
    output logic [pcamg_pkg::OUT_DATA_W-1:0]     m_tdata,
    // kind[1:0]
    output logic [1:0]                           m_tuser,
    input  logic                                 cfg_we,
    input  logic [pcamg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pcamg_pkg::NORM_W-1:0]         cfg_wdata
);

    pcamg_pkg::ctl_t ctl;
    pcamg_pkg::sts_t sts;

    // Sequencer.
    pcamg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Site stores and arithmetic.
    pcamg_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

>>> hw/rtl/pcamg_ctrl.sv
module pcamg_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  pcamg_pkg::sts_t   sts,
    output pcamg_pkg::ctl_t   ctl
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DISP   = 8'b0000_0010,
        ST_SWEEP  = 8'b0000_0100,
        ST_DRAIN  = 8'b0000_1000,
        ST_MRD    = 8'b0001_0000,
        ST_MWR    = 8'b0010_0000,
        ST_CLEAR  = 8'b0100_0000,
        ST_RESULT = 8'b1000_0000
    } state_t;

    state_t                      state_reg, state_next;
    logic [pcamg_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic [1:0]                  drain_reg, drain_next;
    pcamg_pkg::sweep_t           mode_reg, mode_next;
    logic                        out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // State and sweep sequencing.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        drain_next     = drain_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ctl            = '0;
        ctl.asel       = pcamg_pkg::ASEL_CNT;
        ctl.mode       = mode_reg;
        ctl.addr       = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP:
            begin
                cnt_next   = '0;
                drain_next = '0;
                case (sts.op)
                    pcamg_pkg::OP_LOAD:
                    begin
                        ctl.wr_site = 1'b1;
                        state_next  = ST_RESULT;
                    end
                    pcamg_pkg::OP_POINT:
                    begin
                        mode_next  = pcamg_pkg::SW_POINT;
                        state_next = ST_SWEEP;
                    end
                    pcamg_pkg::OP_FINISH:
                    begin
                        mode_next  = pcamg_pkg::SW_NORM;
                        state_next = ST_SWEEP;
                    end
                    default:
                    begin
                        ctl.rd_en  = 1'b1;
                        ctl.asel   = pcamg_pkg::ASEL_ITEM;
                        ctl.mode   = pcamg_pkg::SW_MASS;
                        mode_next  = pcamg_pkg::SW_MASS;
                        state_next = ST_DRAIN;
                    end
                endcase
            end
            ST_SWEEP:
            begin
                ctl.rd_en = 1'b1;
                ctl.first = (cnt_reg == '0);
                if (cnt_reg == sts.last_idx)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // Let the three-stage pipeline empty before acting on its result.
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd3)
                begin
                    case (mode_reg)
                        pcamg_pkg::SW_POINT:
                        begin
                            state_next = ST_MRD;
                        end
                        pcamg_pkg::SW_NORM:
                        begin
                            if (sts.converged)
                            begin
                                state_next = ST_CLEAR;
                            end
                            else
                            begin
                                mode_next  = pcamg_pkg::SW_UPD;
                                cnt_next   = '0;
                                state_next = ST_SWEEP;
                            end
                        end
                        pcamg_pkg::SW_UPD:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_MRD:
            begin
                ctl.rd_en  = 1'b1;
                ctl.asel   = pcamg_pkg::ASEL_WIN;
                ctl.mode   = pcamg_pkg::SW_MASS;
                state_next = ST_MWR;
            end
            ST_MWR:
            begin
                ctl.acc_wr = 1'b1;
                state_next = ST_RESULT;
            end
            ST_CLEAR:
            begin
                ctl.clear_mass = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                // The output register is free or drains in this cycle.
                if (!out_valid_reg || m_tready)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            drain_reg     <= '0;
            mode_reg      <= pcamg_pkg::SW_POINT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            drain_reg     <= drain_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/pcamg_dp.sv
module pcamg_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [pcamg_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [1:0]                           s_tuser,
    output logic [pcamg_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [1:0]                           m_tuser,
    input  logic                                 cfg_we,
    input  logic [pcamg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pcamg_pkg::NORM_W-1:0]         cfg_wdata,
    input  pcamg_pkg::ctl_t                      ctl,
    output pcamg_pkg::sts_t                      sts
);

    localparam int CB = pcamg_pkg::COORD_BITS;
    localparam int AW = pcamg_pkg::IDX_W;
    localparam int NS = pcamg_pkg::MAX_SITES;

    // Configuration registers.
    logic [pcamg_pkg::NSITE_W-1:0] nsite_reg;
    logic [pcamg_pkg::STEP_W-1:0]  step_reg;
    logic [pcamg_pkg::NORM_W-1:0]  thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nsite_reg <= 7'd1;
            step_reg  <= 16'd6554;
            thr_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pcamg_pkg::CFG_SITES: nsite_reg <= cfg_wdata[pcamg_pkg::NSITE_W-1:0];
                pcamg_pkg::CFG_STEP:  step_reg  <= cfg_wdata[pcamg_pkg::STEP_W-1:0];
                pcamg_pkg::CFG_THR:   thr_reg   <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    // Last searched site, with the count clamped to one .. MAX_SITES.
    logic [AW-1:0] last_idx_c;

    always_comb
    begin
        if (nsite_reg == '0)
        begin
            last_idx_c = '0;
        end
        else if (int'(nsite_reg) > NS)
        begin
            last_idx_c = AW'(NS - 1);
        end
        else
        begin
            last_idx_c = AW'(nsite_reg - 1'b1);
        end
    end

    assign sts.last_idx = last_idx_c;

    // Item registers.
    pcamg_pkg::op_t                  op_reg;
    logic [pcamg_pkg::SITE_W-1:0]    idx_reg;
    logic signed [CB-1:0]            px_reg, py_reg, pz_reg;
    logic [pcamg_pkg::W_W-1:0]       w_reg;
    logic [pcamg_pkg::H_W-1:0]       h0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= pcamg_pkg::OP_LOAD;
        end
        else if (ctl.capture)
        begin
            op_reg <= pcamg_pkg::op_t'(s_tuser);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            idx_reg <= s_tdata[5:0];
            px_reg  <= CB'(s_tdata[21:6]);
            py_reg  <= CB'(s_tdata[37:22]);
            pz_reg  <= CB'(s_tdata[53:38]);
            w_reg   <= s_tdata[85:54];
            h0_reg  <= s_tdata[117:86];
        end
    end

    assign sts.op = op_reg;

    logic          idx_ok;
    logic [AW-1:0] item_addr;
    assign idx_ok    = (int'(idx_reg) < NS);
    assign item_addr = AW'(idx_reg);

    // Site stores.
    logic signed [CB-1:0]          mem_x [NS];
    logic signed [CB-1:0]          mem_y [NS];
    logic signed [CB-1:0]          mem_z [NS];
    logic [pcamg_pkg::W_W-1:0]     mem_tgt [NS];
    logic signed [pcamg_pkg::H_W-1:0] mem_off [NS];
    logic [pcamg_pkg::MASS_W-1:0]  mem_acc [NS];
    logic [NS-1:0]                 acc_vld_reg;

    // Search and pass results.
    logic signed [pcamg_pkg::SC_W-1:0] best_reg;
    logic [AW-1:0]                     win_reg;
    logic [pcamg_pkg::NORM_W-1:0]      norm_reg;
    logic                              nonpos_reg;
    logic                              upd_wr;

    logic [AW-1:0] raddr;
    always_comb
    begin
        case (ctl.asel)
            pcamg_pkg::ASEL_WIN:  raddr = win_reg;
            pcamg_pkg::ASEL_ITEM: raddr = item_addr;
            default:              raddr = ctl.addr;
        endcase
    end

    // Stage 1: registered reads.
    logic signed [CB-1:0]             rd_x, rd_y, rd_z;
    logic [pcamg_pkg::W_W-1:0]        rd_tgt;
    logic signed [pcamg_pkg::H_W-1:0] rd_off;
    logic [pcamg_pkg::MASS_W-1:0]     rd_acc_raw;
    logic                             rd_acc_vld;
    logic [pcamg_pkg::MASS_W-1:0]     rd_acc;
    logic                             v1_reg, first1_reg;
    pcamg_pkg::sweep_t                mode1_reg;
    logic [AW-1:0]                    idx1_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_x       <= mem_x[raddr];
            rd_y       <= mem_y[raddr];
            rd_z       <= mem_z[raddr];
            rd_tgt     <= mem_tgt[raddr];
            rd_off     <= mem_off[raddr];
            rd_acc_raw <= mem_acc[raddr];
            rd_acc_vld <= acc_vld_reg[raddr];
            first1_reg <= ctl.first;
            mode1_reg  <= ctl.mode;
            idx1_reg   <= raddr;
        end
    end

    assign rd_acc = rd_acc_vld ? rd_acc_raw : '0;

    // Stage 2: squares, gradient square and step product.
    localparam int DIFF_W_L = pcamg_pkg::DIFF_W;
    logic signed [DIFF_W_L-1:0] dx, dy, dz;
    logic signed [pcamg_pkg::SQ_W-1:0] sqx_c, sqy_c, sqz_c;
    logic signed [pcamg_pkg::G_W-1:0]  g;
    logic [pcamg_pkg::G_W-1:0]         g_abs;
    logic [pcamg_pkg::NORM_W-1:0]      sqn_c;
    logic signed [pcamg_pkg::P_W-1:0]  prod_c;

    always_comb
    begin
        dx     = {px_reg[CB-1], px_reg} - {rd_x[CB-1], rd_x};
        dy     = {py_reg[CB-1], py_reg} - {rd_y[CB-1], rd_y};
        dz     = {pz_reg[CB-1], pz_reg} - {rd_z[CB-1], rd_z};
        sqx_c  = dx * dx;
        sqy_c  = dy * dy;
        sqz_c  = dz * dz;
        g      = $signed({1'b0, rd_acc}) - $signed({7'b0, rd_tgt});
        g_abs  = g[pcamg_pkg::G_W-1] ? -g : g;
        if (|g_abs[pcamg_pkg::G_W-1:31])
        begin
            sqn_c = pcamg_pkg::NORM_MAX;
        end
        else
        begin
            sqn_c = g_abs[30:0] * g_abs[30:0];
        end
        prod_c = $signed({1'b0, step_reg}) * g;
    end

    logic [pcamg_pkg::SQ_W-1:0]       sqx_reg, sqy_reg, sqz_reg;
    logic [pcamg_pkg::NORM_W-1:0]     sqn_reg;
    logic signed [pcamg_pkg::P_W-1:0] prod_reg;
    logic signed [pcamg_pkg::H_W-1:0] off2_reg;
    logic                             v2_reg, first2_reg;
    pcamg_pkg::sweep_t                mode2_reg;
    logic [AW-1:0]                    idx2_reg;

    always_ff @(posedge clk)
    begin
        sqx_reg    <= sqx_c;
        sqy_reg    <= sqy_c;
        sqz_reg    <= sqz_c;
        sqn_reg    <= sqn_c;
        prod_reg   <= prod_c;
        off2_reg   <= rd_off;
        first2_reg <= first1_reg;
        mode2_reg  <= mode1_reg;
        idx2_reg   <= idx1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.rd_en;
            v2_reg <= v1_reg;
        end
    end

    // Stage 3: score compare, norm sum and offset update.
    localparam int P_W1 = pcamg_pkg::P_W + 1;
    logic signed [pcamg_pkg::SC_W-1:0] sc;
    logic [pcamg_pkg::NORM_W:0]        norm_sum;
    logic signed [P_W1-1:0]            rnd;
    logic signed [P_W1-17:0]           delta;
    logic signed [P_W1-15:0]           h_new;
    logic signed [pcamg_pkg::H_W-1:0]  h_sat;

    always_comb
    begin
        sc = $signed(pcamg_pkg::SC_W'(sqx_reg)) + $signed(pcamg_pkg::SC_W'(sqy_reg))
           + $signed(pcamg_pkg::SC_W'(sqz_reg)) - pcamg_pkg::SC_W'(off2_reg);
        norm_sum = {1'b0, norm_reg} + {1'b0, sqn_reg};
        rnd   = {prod_reg[pcamg_pkg::P_W-1], prod_reg} + P_W1'(32768);
        delta = rnd[P_W1-1:16];
        h_new = (P_W1-14)'(off2_reg) - (P_W1-14)'(delta);
        if (h_new > (P_W1-14)'(64'sd2147483647))
        begin
            h_sat = 32'sh7FFF_FFFF;
        end
        else if (h_new < -(P_W1-14)'(64'sd2147483648))
        begin
            h_sat = 32'sh8000_0000;
        end
        else
        begin
            h_sat = h_new[pcamg_pkg::H_W-1:0];
        end
    end

    assign upd_wr = v2_reg && (mode2_reg == pcamg_pkg::SW_UPD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg   <= '0;
            win_reg    <= '0;
            norm_reg   <= '0;
            nonpos_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            norm_reg   <= '0;
            nonpos_reg <= 1'b0;
        end
        else if (v2_reg)
        begin
            case (mode2_reg)
                pcamg_pkg::SW_POINT:
                begin
                    if (first2_reg || (sc < best_reg))
                    begin
                        best_reg <= sc;
                        win_reg  <= idx2_reg;
                    end
                end
                pcamg_pkg::SW_NORM:
                begin
                    norm_reg <= norm_sum[pcamg_pkg::NORM_W] ? pcamg_pkg::NORM_MAX
                                                            : norm_sum[pcamg_pkg::NORM_W-1:0];
                end
                pcamg_pkg::SW_UPD:
                begin
                    if (h_sat <= 0)
                    begin
                        nonpos_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign sts.converged = (norm_reg < thr_reg);

    // Site writes: a load or the offset update.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_site && idx_ok)
        begin
            mem_x[item_addr]   <= px_reg;
            mem_y[item_addr]   <= py_reg;
            mem_z[item_addr]   <= pz_reg;
            mem_tgt[item_addr] <= w_reg;
            mem_off[item_addr] <= h0_reg;
        end
        else if (upd_wr)
        begin
            mem_off[idx2_reg] <= h_sat;
        end
    end

    // Mass accumulation into the winning cell, saturating.
    logic [pcamg_pkg::MASS_W:0]   acc_sum;
    logic [pcamg_pkg::MASS_W-1:0] acc_new;
    assign acc_sum = {1'b0, rd_acc} + (pcamg_pkg::MASS_W + 1)'(w_reg);
    assign acc_new = acc_sum[pcamg_pkg::MASS_W] ? pcamg_pkg::MASS_MAX
                                                : acc_sum[pcamg_pkg::MASS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.acc_wr)
        begin
            mem_acc[win_reg] <= acc_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= '0;
        end
        else if (ctl.clear_mass)
        begin
            acc_vld_reg <= '0;
        end
        else if (ctl.acc_wr)
        begin
            acc_vld_reg[win_reg] <= 1'b1;
        end
    end

    // Result register.
    logic [pcamg_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [1:0]                       out_user_reg;
    logic [pcamg_pkg::SCORE_W-1:0]    score_out;
    logic [pcamg_pkg::OUT_DATA_W-1:0] res;
    longint                           best_l;

    always_comb
    begin
        best_l = longint'(best_reg);
        if (best_l > pcamg_pkg::SCORE_MAX)
        begin
            score_out = pcamg_pkg::SCORE_W'(pcamg_pkg::SCORE_MAX);
        end
        else if (best_l < pcamg_pkg::SCORE_MIN)
        begin
            score_out = pcamg_pkg::SCORE_W'(pcamg_pkg::SCORE_MIN);
        end
        else
        begin
            score_out = pcamg_pkg::SCORE_W'(best_l);
        end
        res = '0;
        case (op_reg)
            pcamg_pkg::OP_POINT:
            begin
                res[5:0]  = pcamg_pkg::SITE_W'(win_reg);
                res[53:6] = score_out;
            end
            pcamg_pkg::OP_FINISH:
            begin
                res[185:124] = norm_reg;
                res[186]     = sts.converged;
                res[187]     = nonpos_reg;
            end
            pcamg_pkg::OP_READ:
            begin
                if (idx_ok)
                begin
                    res[91:54]  = rd_acc;
                    res[123:92] = rd_off;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_data_reg <= res;
            out_user_reg <= op_reg;
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

endmodule

>>> hw/rtl/pcamg_chk.sv
`include "power_cell_assign_mass_gradient_top_macros.svh"

module pcamg_chk
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pcamg_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]                       m_tuser
);

    logic res_stall;
    logic load_beat;
    logic conv_beat;

    assign res_stall = m_tvalid && !m_tready;
    assign load_beat = m_tvalid && (m_tuser == pcamg_pkg::OP_LOAD);
    assign conv_beat = m_tvalid && (m_tuser == pcamg_pkg::OP_FINISH) && m_tdata[186];

    // A result beat that is not taken stays put.
    `PCAMG_ASSERT_NEXT(a_hold, res_stall, m_tvalid && $stable(m_tdata), "result moved under stall")

    // The block works on one beat at a time.
    `PCAMG_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "accepted a beat while busy")

    // A load result carries nothing but its kind.
    `PCAMG_ASSERT_SAME(a_load_zero, load_beat, m_tdata == '0, "load result not empty")

    // A converged pass leaves the offsets alone.
    `PCAMG_ASSERT_SAME(a_conv_keep, conv_beat, !m_tdata[187], "converged pass flagged an offset")

endmodule

bind power_cell_assign_mass_gradient_top pcamg_chk u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb_power_cell_assign_mass_gradient_top.sv
module tb_power_cell_assign_mass_gradient_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    // One input beat, unpacked.
    typedef struct {
        pcamg_pkg::op_t op;
        logic [5:0]     idx;
        logic [15:0]    x;
        logic [15:0]    y;
        logic [15:0]    z;
        logic [31:0]    w;
        logic [31:0]    h0;
    } item_t;

    // Result fields in the same order as m_tdata, highest field first.
    typedef struct packed {
        logic        nonpos;
        logic        conv;
        logic [61:0] norm;
        logic [31:0] h;
        logic [37:0] mass;
        logic [47:0] score;
        logic [5:0]  site;
    } result_t;

    typedef struct {
        pcamg_pkg::op_t kind;
        result_t        res;
    } expect_t;

    // A directed row: the beat, and an optional typed-in read result.
    typedef struct {
        item_t       it;
        logic        typed;
        logic [37:0] mass;
        logic [31:0] h;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [pcamg_pkg::IN_DATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [pcamg_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_we = 1'b0;
    logic [pcamg_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [pcamg_pkg::NORM_W-1:0] cfg_wdata = '0;

    power_cell_assign_mass_gradient_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Shadow copy of the block's settings and site store.
    logic [6:0]         sites_reg = 7'd1;
    logic [15:0]        step_reg = 16'd6554;
    logic [61:0]        thr_reg = '0;
    logic signed [15:0] site_x [64];
    logic signed [15:0] site_y [64];
    logic signed [15:0] site_z [64];
    logic [31:0]        site_target [64];
    logic signed [31:0] site_h [64];
    logic [37:0]        site_mass [64];
    logic               site_loaded [64];

    expect_t pending_results[$];
    int      mismatches = 0;
    int      cycles = 0;
    logic    steady = 1'b0;
    int      ready_wait = 0;

    // Predict the result of one beat and advance the shadow state.
    function automatic result_t predict_power_step(item_t it);
        result_t r;
        int n;
        int win;
        longint best, sc, dx, dy, dz, g, p, d, hn;
        longint unsigned a, sq, norm, m;
        logic nonpos;
        r = '0;
        n = (sites_reg == 0) ? 1 : ((sites_reg > 64) ? 64 : int'(sites_reg));
        case (it.op)
            pcamg_pkg::OP_LOAD:
            begin
                site_x[it.idx] = it.x;
                site_y[it.idx] = it.y;
                site_z[it.idx] = it.z;
                site_target[it.idx] = it.w;
                site_h[it.idx] = it.h0;
                site_loaded[it.idx] = 1'b1;
            end
            pcamg_pkg::OP_POINT:
            begin
                best = 0;
                win = 0;
                for (int i = 0; i < n; i++)
                begin
                    dx = longint'($signed(it.x)) - longint'(site_x[i]);
                    dy = longint'($signed(it.y)) - longint'(site_y[i]);
                    dz = longint'($signed(it.z)) - longint'(site_z[i]);
                    sc = dx * dx + dy * dy + dz * dz - longint'(site_h[i]);
                    if (i == 0 || sc < best)
                    begin
                        best = sc;
                        win = i;
                    end
                end
                if (best > pcamg_pkg::SCORE_MAX) best = pcamg_pkg::SCORE_MAX;
                if (best < pcamg_pkg::SCORE_MIN) best = pcamg_pkg::SCORE_MIN;
                m = longint'(site_mass[win]) + longint'(it.w);
                site_mass[win] = (m > longint'(pcamg_pkg::MASS_MAX)) ? pcamg_pkg::MASS_MAX
                                                                     : m[37:0];
                r.site = win[5:0];
                r.score = best[47:0];
            end
            pcamg_pkg::OP_FINISH:
            begin
                norm = 0;
                nonpos = 1'b0;
                for (int i = 0; i < n; i++)
                begin
                    g = longint'(site_mass[i]) - longint'(site_target[i]);
                    a = (g < 0) ? -g : g;
                    sq = (a >= 64'd2147483648) ? 64'(pcamg_pkg::NORM_MAX) : a * a;
                    norm += sq;
                    if (norm > 64'(pcamg_pkg::NORM_MAX)) norm = 64'(pcamg_pkg::NORM_MAX);
                end
                r.norm = norm[61:0];
                r.conv = (norm < 64'(thr_reg));
                if (!r.conv)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        g = longint'(site_mass[i]) - longint'(site_target[i]);
                        p = longint'(step_reg) * g;
                        d = (p + 32768) >>> 16;
                        hn = longint'(site_h[i]) - d;
                        if (hn > 64'sd2147483647) hn = 64'sd2147483647;
                        if (hn < -64'sd2147483648) hn = -64'sd2147483648;
                        site_h[i] = hn[31:0];
                        if (hn <= 0) nonpos = 1'b1;
                    end
                end
                r.nonpos = nonpos;
                for (int i = 0; i < 64; i++) site_mass[i] = '0;
            end
            default:
            begin
                r.mass = site_mass[it.idx];
                r.h = site_h[it.idx];
            end
        endcase
        return r;
    endfunction

    // Send one beat after a random gap and record its expected result.
    task automatic send_item(item_t it, logic typed, logic [37:0] tm, logic [31:0] th);
        int gap;
        expect_t e;
        gap = steady ? 0 : int'($urandom_range(0, 5));
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.op;
        s_tdata <= {2'b00, it.h0, it.w, it.z, it.y, it.x, it.idx};
        do @(posedge clk); while (!s_tready);
        e.kind = it.op;
        e.res = predict_power_step(it);
        if (typed)
        begin
            e.res = '0;
            e.res.mass = tm;
            e.res.h = th;
        end
        pending_results = {pending_results, e};
    endtask

    // Wait until the block is idle, then write one register.
    task automatic write_setting(logic [pcamg_pkg::CFG_ADDR_W-1:0] addr, logic [61:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == pcamg_pkg::CFG_SITES) sites_reg = value[6:0];
        else if (addr == pcamg_pkg::CFG_STEP) step_reg = value[15:0];
        else thr_reg = value;
    endtask

    // Random beat: mostly points, with loads, reads and pass ends mixed in.
    function automatic item_t random_item(logic tight);
        item_t it;
        int pick;
        it.idx = 6'($urandom_range(0, 63));
        it.x = 16'($urandom);
        it.y = 16'($urandom);
        it.z = 16'($urandom);
        it.h0 = $urandom;
        if (tight)
        begin
            it.x = 16'($urandom_range(0, 4) - 2);
            it.y = 16'($urandom_range(0, 4) - 2);
            it.z = 16'($urandom_range(0, 4) - 2);
            it.h0 = $urandom_range(0, 4) - 2;
        end
        it.w = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20);
        if ($urandom_range(0, 15) == 0) it.w = 32'hFFFF_FFFF;
        pick = int'($urandom_range(0, 99));
        if (pick < 60) it.op = pcamg_pkg::OP_POINT;
        else if (pick < 72) it.op = pcamg_pkg::OP_LOAD;
        else if (pick < 80) it.op = pcamg_pkg::OP_FINISH;
        else it.op = pcamg_pkg::OP_READ;
        if (it.op == pcamg_pkg::OP_READ)
            while (!site_loaded[it.idx]) it.idx = 6'($urandom_range(0, 63));
        return it;
    endfunction

    // Receiver: a random stall before each result.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            ready_wait <= 0;
        end
        else if (m_tready && m_tvalid)
        begin
            ready_wait <= steady ? 0 : int'($urandom_range(0, 5));
            m_tready <= 1'b0;
        end
        else if (!m_tready)
        begin
            if (ready_wait == 0) m_tready <= 1'b1;
            else ready_wait <= ready_wait - 1;
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        expect_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: kind %0d data %h", m_tuser, m_tdata);
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_tuser !== e.kind || m_tdata !== {4'b0000, e.res})
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch kind %0d: expected %h, got kind %0d data %h",
                                 e.kind, {4'b0000, e.res}, m_tuser, m_tdata);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        row_t rows[$];
        row_t rw;
        item_t it;
        for (int i = 0; i < 64; i++)
        begin
            site_x[i] = '0;
            site_y[i] = '0;
            site_z[i] = '0;
            site_target[i] = '0;
            site_h[i] = '0;
            site_mass[i] = '0;
            site_loaded[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: extremes, every operation, unused sites, index 63.
        rw.typed = 1'b0;
        rw.mass = '0;
        rw.h = '0;
        rw.it = '{pcamg_pkg::OP_LOAD, 6'd0, 16'h7FFF, 16'h8000, 16'h0000,
                  32'hFFFF_FFFF, 32'h7FFF_FFFF};
        rows = {rows, rw};
        rw.typed = 1'b1;
        rw.h = 32'h7FFF_FFFF;
        rw.it = '{pcamg_pkg::OP_READ, 6'd0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0};
        rows = {rows, rw};
        rw.typed = 1'b0;
        rw.it = '{pcamg_pkg::OP_POINT, 6'd63, 16'h8000, 16'h7FFF, 16'h7FFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF};
        rows = {rows, rw};
        rw.it = '{pcamg_pkg::OP_POINT, 6'd0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0};
        rows = {rows, rw};
        rw.it = '{pcamg_pkg::OP_READ, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF};
        rows = {rows, rw};
        rw.it = '{pcamg_pkg::OP_FINISH, 6'd0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0};
        rows = {rows, rw};
        rw.it = '{pcamg_pkg::OP_READ, 6'd0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0};
        rows = {rows, rw};
        rw.it = '{pcamg_pkg::OP_LOAD, 6'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  32'h0, 32'h8000_0000};
        rows = {rows, rw};
        rw.typed = 1'b1;
        rw.h = 32'h8000_0000;
        rw.it = '{pcamg_pkg::OP_READ, 6'd1, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0};
        rows = {rows, rw};
        rw.typed = 1'b0;
        rw.it = '{pcamg_pkg::OP_LOAD, 6'd63, 16'h0001, 16'h0001, 16'h0001,
                  32'h0100_0000, 32'h0000_0001};
        rows = {rows, rw};
        rw.typed = 1'b1;
        rw.h = 32'h0000_0001;
        rw.it = '{pcamg_pkg::OP_READ, 6'd63, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0};
        rows = {rows, rw};
        rw.typed = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            rw.it = '{pcamg_pkg::OP_POINT, 6'd0, 16'h7FFF, 16'h8000, 16'h0,
                      32'hFFFF_FFFF, 32'h0};
            rows = {rows, rw};
        end
        rw.it = '{pcamg_pkg::OP_FINISH, 6'd63, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF};
        rows = {rows, rw};
        rw.it = '{pcamg_pkg::OP_READ, 6'd0, 16'h0, 16'h0, 16'h0, 32'h0, 32'h0};
        rows = {rows, rw};
        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].mass, rows[i].h);

        // Load every site once so all later searches and reads see written entries.
        write_setting(pcamg_pkg::CFG_SITES, 62'd64);
        write_setting(pcamg_pkg::CFG_STEP, 62'd65535);
        write_setting(pcamg_pkg::CFG_THR, 62'd0);
        for (int i = 0; i < 64; i++)
        begin
            it = random_item(1'b0);
            it.op = pcamg_pkg::OP_LOAD;
            it.idx = 6'(i);
            send_item(it, 1'b0, '0, '0);
        end

        // Random phases, each under its own settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                1:
                begin
                    write_setting(pcamg_pkg::CFG_SITES, 62'd0);
                    write_setting(pcamg_pkg::CFG_STEP, 62'd0);
                    write_setting(pcamg_pkg::CFG_THR, pcamg_pkg::NORM_MAX);
                end
                2:
                begin
                    write_setting(pcamg_pkg::CFG_SITES, 62'd127);
                    write_setting(pcamg_pkg::CFG_STEP, 62'($urandom_range(0, 65535)));
                    write_setting(pcamg_pkg::CFG_THR, 62'({$urandom, $urandom} >> 2));
                end
                3:
                begin
                    write_setting(pcamg_pkg::CFG_SITES, 62'd5);
                    write_setting(pcamg_pkg::CFG_STEP, 62'd6554);
                    write_setting(pcamg_pkg::CFG_THR,
                                  62'({$urandom, $urandom} >> $urandom_range(2, 40)));
                end
                4:
                begin
                    write_setting(pcamg_pkg::CFG_SITES, 62'd17);
                    write_setting(pcamg_pkg::CFG_STEP, 62'($urandom_range(0, 65535)));
                    write_setting(pcamg_pkg::CFG_THR, 62'd0);
                end
                5:
                begin
                    write_setting(pcamg_pkg::CFG_SITES, 62'd64);
                    write_setting(pcamg_pkg::CFG_THR, pcamg_pkg::NORM_MAX >> 1);
                end
                default: ;
            endcase
            steady = (ph == 4);
            for (int k = 0; k < 200; k++)
                send_item(random_item(ph == 3 || ph == 5), 1'b0, '0, '0);
        end

        // Drain and report.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
